### sv/mstt_pkg.sv
// package: types, codes and sizes shared by the timer table files
package mstt_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IdW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [1:0] KIND_REGISTERED = 2'd0;
  localparam logic [1:0] KIND_REFUSED    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] start_count;
    logic [15:0] reload_period;
    logic [5:0]  slot_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] slot_id;
    logic       freed;
    logic       last_event;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REG,
    ST_TICK,
    ST_FLUSH
  } state_e;

endpackage

### sv/mstt_if.sv
// interfaces: request and result channels with valid/ready handshake
interface mstt_in_if import mstt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mstt_out_if import mstt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/multi_slot_timer_table_core.sv
// Timer table of SLOTS slots (register, delete, tick) with one shared slot
// unit stepped by a small sequencer. A delete clears its slot as it is
// accepted. A register scans slots from id 0, one per cycle, and takes the
// first free one, or is refused when all are in use. A tick visits every
// slot through the single decrement/compare unit, one per cycle while the
// result side does not hold back the output register. One finished result
// is held back one step so that the final one can be marked; the input is
// taken again once the last result of the item sits in the output register.
module multi_slot_timer_table_core import mstt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mstt_in_if.sink    req_i,
  mstt_out_if.source rsp_o
);

  state_e state_q, state_d;
  logic [IdW-1:0] idx_q;
  logic [SLOTS-1:0] in_use_q;
  logic [15:0] rem_q [SLOTS];
  logic [15:0] per_q [SLOTS];
  logic [15:0] start_q, period_q;

  logic        pv_q, ov_q;
  logic [1:0]  pkind_q;
  logic [6:0]  pid_q;
  logic        pfreed_q;
  out_item_t   out_q;

  logic        accept, out_free, idx_last;
  logic [15:0] rem_rd, per_rd, dec;
  logic        slot_used, hit;

  logic in_ready, reg_found, reg_full, tick_step, pend_push, last_push, flush_done;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !ov_q || rsp_o.ready;
  assign idx_last = (idx_q == IdW'(SLOTS - 1));

  // shared slot unit
  assign rem_rd    = rem_q[idx_q];
  assign per_rd    = per_q[idx_q];
  assign slot_used = in_use_q[idx_q];
  assign dec       = (rem_rd != 16'd0) ? (rem_rd - 16'd1) : 16'd0;
  assign hit       = slot_used && (dec == 16'd0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.data.operation == OP_REGISTER) state_d = ST_REG;
          else if (req_i.data.operation == OP_TICK) state_d = ST_TICK;
        end
      end
      ST_REG: begin
        if (!slot_used || idx_last) state_d = ST_FLUSH;
      end
      ST_TICK: begin
        if (tick_step && idx_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    reg_found  = 1'b0;
    reg_full   = 1'b0;
    tick_step  = 1'b0;
    pend_push  = 1'b0;
    last_push  = 1'b0;
    flush_done = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_REG: begin
        reg_found = !slot_used;
        reg_full  = slot_used && idx_last;
      end
      ST_TICK: begin
        tick_step = !(hit && pv_q && !out_free);
        pend_push = hit && pv_q && out_free;
      end
      ST_FLUSH: begin
        last_push  = pv_q && out_free;
        flush_done = !pv_q || out_free;
      end
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;
  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      in_use_q <= '0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d == ST_REG || state_d == ST_TICK) begin
        if ((state_q == ST_REG) || (state_q == ST_TICK && tick_step)) idx_q <= idx_q + IdW'(1);
      end else begin
        idx_q <= '0;
      end
      if (accept && req_i.data.operation == OP_DELETE &&
          ({1'b0, req_i.data.slot_select} < 7'(SLOTS))) begin
        in_use_q[req_i.data.slot_select[IdW-1:0]] <= 1'b0;
      end
      if (reg_found) in_use_q[idx_q] <= 1'b1;
      if (tick_step && hit && per_rd == 16'd0) in_use_q[idx_q] <= 1'b0;
      if (reg_found || reg_full || (tick_step && hit)) pv_q <= 1'b1;
      else if (last_push) pv_q <= 1'b0;
      if (pend_push || last_push) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q  <= req_i.data.start_count;
      period_q <= req_i.data.reload_period;
    end
    if (reg_found) begin
      rem_q[idx_q] <= start_q;
      per_q[idx_q] <= period_q;
    end
    if (tick_step && slot_used) rem_q[idx_q] <= hit ? per_rd : dec;
    if (pend_push || last_push) begin
      out_q.event_kind <= pkind_q;
      out_q.slot_id    <= pid_q;
      out_q.freed      <= pfreed_q;
      out_q.last_event <= last_push;
    end
    if (reg_found || reg_full) begin
      pkind_q  <= reg_found ? KIND_REGISTERED : KIND_REFUSED;
      pid_q    <= reg_found ? 7'(idx_q) : 7'(SLOTS);
      pfreed_q <= 1'b0;
    end else if (tick_step && hit) begin
      pkind_q  <= KIND_EXPIRED;
      pid_q    <= 7'(idx_q);
      pfreed_q <= (per_rd == 16'd0);
    end
  end

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pv_q)
    else $error("held result left over in idle");

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> idx_q == '0)
    else $error("slot index not rewound");

  a_refused_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.event_kind == KIND_REFUSED |->
      rsp_o.data.slot_id == 7'(SLOTS) && rsp_o.data.last_event)
    else $error("refused result malformed");

  a_tick_enters_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.data.operation == OP_TICK |=> state_q == ST_TICK)
    else $error("tick did not start sweep");

endmodule

### bench/tb_multi_slot_timer_table_core.sv
// testbench: directed and random timer requests checked against a self-contained table model
module tb_multi_slot_timer_table_core import mstt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  class timer_event_scoreboard;
    bit          slot_busy [SLOTS];
    logic [15:0] ticks_left [SLOTS];
    logic [15:0] reload_ticks [SLOTS];
    out_item_t   pending_events [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned expiries_seen;
    int unsigned refusals_seen;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        clear_entry(s);
      end
    endfunction

    function void clear_entry(int unsigned s);
      slot_busy[s]    = 1'b0;
      ticks_left[s]   = '0;
      reload_ticks[s] = '0;
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction

    function void note_request(in_item_t req);
      out_item_t   batch [$];
      out_item_t   ev;
      int unsigned s;
      ev = '0;
      case (req.operation)
        OP_REGISTER: begin
          s = 0;
          while (s < SLOTS && slot_busy[s]) s++;
          if (s < SLOTS) begin
            slot_busy[s]    = 1'b1;
            ticks_left[s]   = req.start_count;
            reload_ticks[s] = req.reload_period;
          end
          ev.event_kind = (s < SLOTS) ? KIND_REGISTERED : KIND_REFUSED;
          ev.slot_id    = 7'(s);
          batch.push_back(ev);
        end
        OP_DELETE: begin
          if (req.slot_select < SLOTS) clear_entry(req.slot_select);
        end
        OP_TICK: begin
          for (s = 0; s < SLOTS; s++) begin
            if (!slot_busy[s]) continue;
            if (ticks_left[s] != 0) ticks_left[s] = ticks_left[s] - 16'd1;
            if (ticks_left[s] != 0) continue;
            ev.event_kind = KIND_EXPIRED;
            ev.slot_id    = 7'(s);
            ev.freed      = (reload_ticks[s] == 0);
            if (ev.freed) clear_entry(s);
            else ticks_left[s] = reload_ticks[s];
            batch.push_back(ev);
          end
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last_event = 1'b1;
      foreach (batch[i]) pending_events.push_back(batch[i]);
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (pending_events.size() == 0) begin
        $error("result with nothing expected: event_kind %0d slot_id %0d",
               got.event_kind, got.slot_id);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      results_seen++;
      if (want.event_kind == KIND_EXPIRED) expiries_seen++;
      if (want.event_kind == KIND_REFUSED) refusals_seen++;
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
        mismatches++;
      end
      if (got.slot_id !== want.slot_id) begin
        $error("slot_id: expected %0d, actual %0d", want.slot_id, got.slot_id);
        mismatches++;
      end
      if (got.freed !== want.freed) begin
        $error("freed: expected %0d, actual %0d", want.freed, got.freed);
        mismatches++;
      end
      if (got.last_event !== want.last_event) begin
        $error("last_event: expected %0d, actual %0d", want.last_event, got.last_event);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mstt_in_if  req_if ();
  mstt_out_if rsp_if ();

  timer_event_scoreboard sb = new();

  bit          steady_flow;
  int unsigned long_stall;
  int unsigned requests_sent;

  multi_slot_timer_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic in_item_t make_req(logic [1:0] op, logic [15:0] start,
                                        logic [15:0] period, logic [5:0] sel);
    in_item_t req;
    req.operation     = op;
    req.start_count   = start;
    req.reload_period = period;
    req.slot_select   = sel;
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic collect_results();
    int unsigned hold;
    forever begin
      if (long_stall != 0) begin
        hold = long_stall;
        long_stall = 0;
      end else begin
        hold = steady_flow ? 0 : $urandom_range(0, 8);
      end
      if (hold != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      sb.check_event(rsp_if.data);
    end
  endtask

  task automatic run_random_phase(int unsigned count);
    in_item_t    req;
    int unsigned pick;
    int unsigned spread;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      req.operation = (pick < 38) ? OP_REGISTER :
                      (pick < 60) ? OP_DELETE :
                      (pick < 96) ? OP_TICK : OP_UNUSED;
      spread = $urandom_range(0, 9);
      req.start_count = (spread < 6) ? 16'($urandom_range(0, 3)) :
                        (spread < 8) ? 16'($urandom_range(0, 20)) : 16'($urandom);
      spread = $urandom_range(0, 9);
      req.reload_period = (spread < 4) ? 16'd0 :
                          (spread < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
      req.slot_select = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, SLOTS - 1)) :
                                                        6'($urandom_range(0, 63));
      send_request(req);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rsp_if.ready <= 1'b0;
    steady_flow   = 1'b0;
    long_stall    = 0;
    requests_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      collect_results();
    join_none

    // directed corners
    send_request(make_req(OP_TICK, 16'd0, 16'd0, 6'd0));
    send_request(make_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63));
    send_request(make_req(OP_DELETE, 16'd0, 16'd0, 6'd63));
    send_request(make_req(OP_DELETE, 16'd0, 16'd0, 6'(SLOTS)));
    send_request(make_req(OP_DELETE, 16'd0, 16'd0, 6'd3));
    send_request(make_req(OP_REGISTER, 16'd0, 16'd0, 6'd0));
    send_request(make_req(OP_REGISTER, 16'hFFFF, 16'hFFFF, 6'd0));
    send_request(make_req(OP_REGISTER, 16'd1, 16'd1, 6'd0));
    send_request(make_req(OP_REGISTER, 16'd2, 16'd0, 6'd0));
    send_request(make_req(OP_TICK, 16'd0, 16'd0, 6'd0));
    send_request(make_req(OP_TICK, 16'd0, 16'd0, 6'd0));
    send_request(make_req(OP_DELETE, 16'd0, 16'd0, 6'd1));
    // fill the table, last one is refused
    repeat (SLOTS) begin
      send_request(make_req(OP_REGISTER, 16'($urandom), 16'($urandom), 6'($urandom)));
    end
    wait_for_results();

    run_random_phase(40);
    wait_for_results();

    // every slot expires on one tick while the result side is held off
    for (int s = 0; s < SLOTS; s++) begin
      send_request(make_req(OP_DELETE, 16'd0, 16'd0, 6'(s)));
    end
    long_stall = 300;
    for (int s = 0; s < SLOTS; s++) begin
      send_request(make_req(OP_REGISTER, 16'd1, 16'($urandom_range(0, 1)), 6'd0));
    end
    send_request(make_req(OP_REGISTER, 16'd1, 16'd1, 6'd0));
    send_request(make_req(OP_TICK, 16'd0, 16'd0, 6'd0));
    send_request(make_req(OP_TICK, 16'd0, 16'd0, 6'd0));
    wait_for_results();

    steady_flow = 1'b1;
    run_random_phase(40);
    steady_flow = 1'b0;
    wait_for_results();
    run_random_phase(40);
    run_random_phase(40);

    wait_for_results();
    repeat (SLOTS + 8) @(posedge clk_i);

    $display("ran %0d requests: %0d results checked, %0d expiries, %0d refusals",
             requests_sent, sb.results_seen, sb.expiries_seen, sb.refusals_seen);
    if (sb.mismatches == 0) begin
      $display("[multi_slot_timer_table_core] OK");
    end else begin
      $display("[multi_slot_timer_table_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results still expected", sb.outstanding());
    $display("[multi_slot_timer_table_core] ERROR");
    $finish;
  end

endmodule
